[src/amau_pkg.sv]
// ============================================================================
// amau_pkg
// Shared types and constants for the anneal move acceptance unit.
// ============================================================================
package amau_pkg;

    localparam int EXP_FRAC     = 24;
    localparam int TAYLOR_TERMS = 12;
    localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

    localparam logic [2:0] REG_HILL_CLIMB  = 3'd0;
    localparam logic [2:0] REG_LENGTH_PRIO = 3'd1;
    localparam logic [2:0] REG_CALIBRATE   = 3'd2;
    localparam logic [2:0] REG_NODE_COUNT  = 3'd3;
    localparam logic [2:0] REG_SYM_DIV     = 3'd4;

    localparam int ADDR_W = 5;

    typedef struct packed {
        logic        hill_climb;
        logic        length_priority;
        logic        calibrate;
        logic [15:0] node_count;
        logic [15:0] symmetry_divisor;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic        half;      // 32 iterations instead of 64
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_stat_t;

endpackage

[src/amau_in_if.sv]
// ============================================================================
// amau_in_if
// Move item channel: valid/ready handshake with the move fields.
// ============================================================================
interface amau_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] cur_diameter;
    logic [15:0] new_diameter;
    logic [31:0] current_length;
    logic [31:0] new_length;
    logic [31:0] temperature;
    logic [31:0] random_word;

    modport source (
        output valid, cur_diameter, new_diameter, current_length, new_length,
               temperature, random_word,
        input  ready
    );
    modport sink (
        input  valid, cur_diameter, new_diameter, current_length, new_length,
               temperature, random_word,
        output ready
    );
endinterface

[src/amau_out_if.sv]
// ============================================================================
// amau_out_if
// Result item channel: valid/ready handshake with the decision fields.
// ============================================================================
interface amau_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [47:0] max_energy;

    modport source (output valid, accepted, max_energy, input ready);
    modport sink (input valid, accepted, max_energy, output ready);
endinterface

[src/amau_cfg_regs.sv]
// ============================================================================
// amau_cfg_regs
// APB register file holding the mode and scaling registers.
// ============================================================================
module amau_cfg_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [amau_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output amau_pkg::cfg_t        cfg
);
    import amau_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hill_climb       <= 1'b0;
            cfg_reg.length_priority  <= 1'b0;
            cfg_reg.calibrate        <= 1'b0;
            cfg_reg.node_count       <= 16'd2;
            cfg_reg.symmetry_divisor <= 16'd1;
        end
        else if (wr)
        begin
            case (idx)
                REG_HILL_CLIMB:  cfg_reg.hill_climb       <= pwdata[0];
                REG_LENGTH_PRIO: cfg_reg.length_priority  <= pwdata[0];
                REG_CALIBRATE:   cfg_reg.calibrate        <= pwdata[0];
                REG_NODE_COUNT:  cfg_reg.node_count       <= pwdata[15:0];
                REG_SYM_DIV:     cfg_reg.symmetry_divisor <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_HILL_CLIMB:  prdata = {31'd0, cfg_reg.hill_climb};
            REG_LENGTH_PRIO: prdata = {31'd0, cfg_reg.length_priority};
            REG_CALIBRATE:   prdata = {31'd0, cfg_reg.calibrate};
            REG_NODE_COUNT:  prdata = {16'd0, cfg_reg.node_count};
            REG_SYM_DIV:     prdata = {16'd0, cfg_reg.symmetry_divisor};
            default:         prdata = 32'd0;
        endcase
    end
endmodule

[src/amau_divider.sv]
// ============================================================================
// amau_divider
// Restoring radix-2 divider, 64-bit dividend by 32-bit divisor, one bit/cycle.
// ============================================================================
module amau_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  amau_pkg::div_cmd_t  cmd,
    output amau_pkg::div_stat_t stat
);
    import amau_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_sh;
    logic        fits;

    assign rem_sh = {rem_reg, dvd_reg[63]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = cmd.half ? 7'd32 : 7'd64;
            dvd_next  = cmd.dividend;
            dvs_next  = cmd.divisor;
            rem_next  = 32'd0;
            quo_next  = 64'd0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
            quo_next = {quo_reg[62:0], fits};
            dvd_next = {dvd_reg[62:0], 1'b0};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;
endmodule

[src/amau_core.sv]
// ============================================================================
// amau_core
// Sequencer for the acceptance rule: shared multiplier, divider control,
// ln2 range reduction, Taylor series for exp and the final random compare.
// ============================================================================
module amau_core #(
    parameter int RANDOM_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  amau_pkg::cfg_t      cfg,
    amau_in_if.sink             move,
    amau_out_if.source          result,
    output amau_pkg::div_cmd_t  div_cmd,
    input  amau_pkg::div_stat_t div_stat
);
    import amau_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_K    = 4'd1;
    localparam logic [3:0] S_E    = 4'd2;
    localparam logic [3:0] S_EW   = 4'd3;
    localparam logic [3:0] S_DIVS = 4'd4;
    localparam logic [3:0] S_CUT  = 4'd5;
    localparam logic [3:0] S_DIVT = 4'd6;
    localparam logic [3:0] S_LN2  = 4'd7;
    localparam logic [3:0] S_MUL  = 4'd8;
    localparam logic [3:0] S_MULW = 4'd9;
    localparam logic [3:0] S_DIVI = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    localparam int CMP_W = RANDOM_BITS + 26;

    logic [3:0]  state_reg, state_next;
    logic        acc_reg, acc_next;
    logic        calib_reg, calib_next;
    logic [47:0] max_reg, max_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_acc_reg, out_acc_next;
    logic [47:0] out_max_reg, out_max_next;

    logic [31:0] d_reg, d_next;
    logic [31:0] t_reg, t_next;
    logic [RANDOM_BITS-1:0] r_reg, r_next;
    logic [63:0] e_reg, e_next;
    logic [36:0] x_reg, x_next;
    logic [4:0]  q_reg, q_next;
    logic [31:0] f_reg, f_next;
    logic [32:0] term_reg, term_next;
    logic [32:0] sum_reg, sum_next;
    logic [3:0]  i_reg, i_next;

    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] prod_reg;

    logic        accept;
    logic        le_len;
    logic [47:0] e_sat;
    logic [36:0] t17;
    logic [32:0] p_full;
    logic [CMP_W-1:0] lhs, rhs;
    logic [15:0] sdiv;

    assign accept      = move.valid && move.ready;
    assign move.ready  = (state_reg == S_IDLE);
    assign le_len      = move.new_length <= move.current_length;
    assign e_sat       = (|prod_reg[63:48]) ? 48'hFFFF_FFFF_FFFF : prod_reg[47:0];
    assign t17         = {t_reg, 4'd0} + {5'd0, t_reg};
    assign p_full      = sum_reg >> (6'(q_reg) + 6'd8);
    assign lhs         = CMP_W'(p_full[24:0]) << RANDOM_BITS;
    assign rhs         = (CMP_W'(r_reg) + CMP_W'(1)) << EXP_FRAC;
    assign sdiv        = (cfg.symmetry_divisor == 16'd0) ? 16'd1 : cfg.symmetry_divisor;

    always_comb
    begin
        mul_a = {1'b0, d_reg};
        mul_b = 32'd0;
        case (state_reg)
            S_K:     begin mul_a = {17'd0, cfg.node_count};
                           mul_b = {16'd0, 16'(cfg.node_count - 16'd1)}; end
            S_E:     begin mul_a = {1'b0, d_reg}; mul_b = prod_reg[31:0]; end
            S_MUL:   begin mul_a = term_reg; mul_b = f_reg; end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * {33'd0, mul_b};
    end

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        calib_next     = calib_reg;
        max_next       = max_reg;
        out_valid_next = out_valid_reg;
        out_acc_next   = out_acc_reg;
        out_max_next   = out_max_reg;
        d_next         = d_reg;
        t_next         = t_reg;
        r_next         = r_reg;
        e_next         = e_reg;
        x_next         = x_reg;
        q_next         = q_reg;
        f_next         = f_reg;
        term_next      = term_reg;
        sum_next       = sum_reg;
        i_next         = i_reg;
        div_cmd        = '0;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    d_next     = move.new_length - move.current_length;
                    t_next     = move.temperature;
                    r_next     = move.random_word[RANDOM_BITS-1:0];
                    calib_next = cfg.calibrate;
                    state_next = S_OUT;
                    if (cfg.calibrate)
                    begin
                        if (move.new_diameter < move.cur_diameter)
                            acc_next = 1'b1;
                        else if (move.new_diameter > move.cur_diameter)
                            acc_next = 1'b0;
                        else if (le_len)
                            acc_next = 1'b1;
                        else
                            state_next = S_K;
                    end
                    else if (cfg.hill_climb)
                        acc_next = le_len;
                    else if (!cfg.length_priority &&
                             move.new_diameter < move.cur_diameter)
                        acc_next = 1'b1;
                    else if (!cfg.length_priority &&
                             move.new_diameter > move.cur_diameter)
                        acc_next = 1'b0;
                    else if (le_len)
                        acc_next = 1'b1;
                    else
                        state_next = S_K;
                end
            end
            S_K:
                state_next = S_E;
            S_E:
                state_next = S_EW;
            S_EW:
            begin
                e_next = prod_reg[63:0];
                if (calib_reg)
                begin
                    if (e_sat > max_reg)
                        max_next = e_sat;
                    state_next = S_CUT;
                end
                else
                begin
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = prod_reg[63:0];
                    div_cmd.divisor  = {16'd0, sdiv};
                    state_next       = S_DIVS;
                end
            end
            S_DIVS:
            begin
                if (div_stat.done)
                begin
                    e_next     = div_stat.quotient;
                    state_next = S_CUT;
                end
            end
            S_CUT:
            begin
                if (e_reg >= {27'd0, t17})
                begin
                    acc_next   = 1'b0;
                    state_next = S_OUT;
                end
                else
                begin
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = e_reg << EXP_FRAC;
                    div_cmd.divisor  = t_reg;
                    state_next       = S_DIVT;
                end
            end
            S_DIVT:
            begin
                if (div_stat.done)
                begin
                    x_next     = {div_stat.quotient[28:0], 8'd0};
                    q_next     = 5'd0;
                    state_next = S_LN2;
                end
            end
            S_LN2:
            begin
                if (x_reg >= {5'd0, LN2_Q32})
                begin
                    x_next = x_reg - {5'd0, LN2_Q32};
                    q_next = q_reg + 5'd1;
                end
                else
                begin
                    f_next     = x_reg[31:0];
                    term_next  = {1'b1, 32'd0};
                    sum_next   = {1'b1, 32'd0};
                    i_next     = 4'd1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
                state_next = S_MULW;
            S_MULW:
            begin
                div_cmd.start    = 1'b1;
                div_cmd.half     = 1'b1;
                div_cmd.dividend = {prod_reg[63:32], 32'd0};
                div_cmd.divisor  = {28'd0, i_reg};
                state_next       = S_DIVI;
            end
            S_DIVI:
            begin
                if (div_stat.done)
                begin
                    term_next = {1'b0, div_stat.quotient[31:0]};
                    if (i_reg[0])
                        sum_next = sum_reg - {1'b0, div_stat.quotient[31:0]};
                    else
                        sum_next = sum_reg + {1'b0, div_stat.quotient[31:0]};
                    if (i_reg == 4'(TAYLOR_TERMS))
                        state_next = S_FIN;
                    else
                    begin
                        i_next     = i_reg + 4'd1;
                        state_next = S_MUL;
                    end
                end
            end
            S_FIN:
            begin
                acc_next   = lhs > rhs;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = acc_reg;
                    out_max_next   = max_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            max_reg       <= 48'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        calib_reg   <= calib_next;
        out_acc_reg <= out_acc_next;
        out_max_reg <= out_max_next;
        d_reg       <= d_next;
        t_reg       <= t_next;
        r_reg       <= r_next;
        e_reg       <= e_next;
        x_reg       <= x_next;
        q_reg       <= q_next;
        f_reg       <= f_next;
        term_reg    <= term_next;
        sum_reg     <= sum_next;
        i_reg       <= i_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.accepted   = out_acc_reg;
    assign result.max_energy = out_max_reg;
endmodule

[src/anneal_move_acceptance_unit.sv]
// Moves decided by diameter, hill-climb or a shorter length go from accept to S_OUT,
// which registers the result once the output is free. Uphill moves use the serial
// divider for energy/divisor (not in calibrate mode) and energy/temperature, unless the
// cutoff rejects them, then ln2 reduction and 12 Taylor terms, each with a divide.
// One item at a time; ready only when idle.
// Reset (rst_n, async active low) clears sequencer, result valid, max energy, registers.
// ============================================================================
// anneal_move_acceptance_unit
// Metropolis acceptance decision for one annealing move per item.
// ============================================================================
module anneal_move_acceptance_unit #(
    parameter int RANDOM_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [amau_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    amau_in_if.sink                     move,
    amau_out_if.source                  result
);
    import amau_pkg::*;

    cfg_t      cfg;
    div_cmd_t  div_cmd;
    div_stat_t div_stat;

    amau_cfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    amau_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .stat  (div_stat)
    );

    amau_core #(
        .RANDOM_BITS (RANDOM_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .move     (move),
        .result   (result),
        .div_cmd  (div_cmd),
        .div_stat (div_stat)
    );
endmodule

[src/amau_checker.sv]
// ============================================================================
// amau_checker
// Port-level checks for the anneal move acceptance unit.
// ============================================================================
module amau_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_accepted,
    input logic [47:0] out_max_energy
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_accepted) && $stable(out_max_energy))
        else $error("result item changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new item taken while previous one still in work");

    a_no_out_at_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");
endmodule

bind anneal_move_acceptance_unit amau_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (move.valid),
    .in_ready       (move.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_accepted   (result.accepted),
    .out_max_energy (result.max_energy)
);
